@@ src/hhn_pkg.sv @@
// Shared types, constants and arithmetic step functions for the heightfield sampler.
package hhn_pkg;

  // Grid and fixed-point geometry.
  localparam int GRID_MAX    = 128;
  localparam int FRAC_BITS   = 8;
  localparam int STORE_DEPTH = GRID_MAX * GRID_MAX;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [7:0] GRID_RESET = 8'd65;

  // Pipeline layout: five front stages, square root, division, output register.
  localparam int SQ_STAGES = 15;
  localparam int DV_STAGES = 8;
  localparam int ST_SQ0    = 5;
  localparam int ST_DV0    = ST_SQ0 + SQ_STAGES;
  localparam int ST_OUT    = ST_DV0 + DV_STAGES;
  localparam int NUM_ST    = ST_OUT + 1;

  localparam logic [15:0] NORM_ONE = 16'd16384;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_OOB   = 2'd1,
    ST_WRITE = 2'd2
  } status_t;

  // Item carried through the normalisation pipeline.
  typedef struct packed {
    status_t                 status;
    logic signed [23:0]      height;
    logic [2:0]              neg;
    logic [2:0][14:0]        mag;
  } item_t;

  // Partial square root state.
  typedef struct packed {
    logic [31:0] rem;
    logic [29:0] root;
  } sq_t;

  // Partial quotient state.
  typedef struct packed {
    logic [29:0] rem;
    logic [15:0] quo;
  } dv_t;

  // One digit of a restoring square root, two radicand bits in.
  function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
    logic [33:0] r;
    logic [33:0] t;
    sq_t         nxt;
    r = {cur.rem, pair};
    t = {2'b00, cur.root, 2'b01};
    if (r >= t) begin
      r = r - t;
      nxt.root = {cur.root[28:0], 1'b1};
    end else begin
      nxt.root = {cur.root[28:0], 1'b0};
    end
    nxt.rem = r[31:0];
    return nxt;
  endfunction

  // One bit of a restoring division.
  function automatic dv_t div_step(input dv_t cur, input logic bit_in,
                                   input logic [29:0] len);
    logic [30:0] w;
    dv_t         nxt;
    w = {cur.rem, bit_in};
    if (w >= {1'b0, len}) begin
      w = w - {1'b0, len};
      nxt.quo = {cur.quo[14:0], 1'b1};
    end else begin
      nxt.quo = {cur.quo[14:0], 1'b0};
    end
    nxt.rem = w[29:0];
    return nxt;
  endfunction

endpackage

@@ src/heightfield_height_and_normal_top.sv @@
// Heightfield sampler: sample store, triangle interpolation and unit normal pipeline.
// Throughput: one word per cycle when the output is not stalled; the four corner reads use four
// copies of the sample store, each with one read port, and the square root and divisions are
// pipelined two steps a stage. Reset clears the pipeline valid bits and sets grid_size to 65;
// the sample store is not cleared and must be written before it is queried.
module heightfield_height_and_normal_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_index[13:0], sample_value[37:14], coord_x[52:38], coord_y[67:53], zero pad
  input  logic [71:0] s_axis_tdata,
  // mode[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // height[23:0], normal_x[39:24], normal_y[55:40], normal_z[71:56]
  output logic [71:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic [hhn_pkg::NUM_ST-1:0] v;
  logic [hhn_pkg::NUM_ST-1:0] en;
  logic                       accept;

  always_comb begin
    en[hhn_pkg::NUM_ST-1] = !v[hhn_pkg::NUM_ST-1] | m_axis_tready;
    for (int k = hhn_pkg::NUM_ST - 2; k >= 0; k--) begin
      en[k] = !v[k] | en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign accept        = s_axis_tvalid & en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_axis_tvalid;
      for (int k = 1; k < hhn_pkg::NUM_ST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Grid size register.
  logic [7:0] grid_size;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= hhn_pkg::GRID_RESET;
    end else if (cfg_valid) begin
      grid_size <= cfg_data;
    end
  end

  // Input decode, range check and corner addresses.
  logic                       in_mode;
  logic [hhn_pkg::ADDR_W-1:0] in_index;
  logic [23:0]                in_value;
  logic [6:0]                 tx, ty;
  logic [7:0]                 ox, oy;
  logic [7:0]                 g;
  logic                       oob;
  logic [14:0]                row0, row1;
  logic [hhn_pkg::ADDR_W-1:0] addr [4];
  hhn_pkg::status_t           in_status;

  always_comb begin
    in_mode  = s_axis_tuser[0];
    in_index = s_axis_tdata[13:0];
    in_value = s_axis_tdata[37:14];
    tx       = s_axis_tdata[52:46];
    ox       = s_axis_tdata[45:38];
    ty       = s_axis_tdata[67:61];
    oy       = s_axis_tdata[60:53];
    g        = (grid_size > 8'(hhn_pkg::GRID_MAX)) ? 8'(hhn_pkg::GRID_MAX) : grid_size;
    oob      = ((8'(tx) + 8'd1) >= g) || ((8'(ty) + 8'd1) >= g);
    row0     = 15'(ty) * 15'(g);
    row1     = row0 + 15'(g);
    addr[0]  = hhn_pkg::ADDR_W'(row0 + 15'(tx));
    addr[1]  = hhn_pkg::ADDR_W'(row1 + 15'(tx));
    addr[2]  = hhn_pkg::ADDR_W'(row1 + 15'(tx) + 15'd1);
    addr[3]  = hhn_pkg::ADDR_W'(row0 + 15'(tx) + 15'd1);
    if (!in_mode)  in_status = hhn_pkg::ST_WRITE;
    else if (oob)  in_status = hhn_pkg::ST_OOB;
    else           in_status = hhn_pkg::ST_DONE;
  end

  // Four copies of the sample store, one per corner; every write goes to all of them.
  logic [23:0] rd [4];

  for (genvar c = 0; c < 4; c++) begin : g_store
    logic [23:0] copy [hhn_pkg::STORE_DEPTH];

    always_ff @(posedge clk) begin
      if (accept && !in_mode) begin
        copy[in_index] <= in_value;
      end
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        rd[c] <= copy[addr[c]];
      end
    end
  end

  // Stage a: control beside the corner reads.
  hhn_pkg::status_t status_a;
  logic [7:0]       ox_a, oy_a;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      status_a <= in_status;
      ox_a     <= ox;
      oy_a     <= oy;
    end
  end

  // Stage b: triangle choice, edge differences and the raw normal.
  hhn_pkg::status_t   status_b;
  logic [7:0]         ox_b, oy_b;
  logic signed [23:0] h1_b;
  logic signed [24:0] da_b, db_b;
  logic signed [25:0] v0_b, v1_b;
  logic [9:0]         v2_b;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      status_b <= status_a;
      ox_b     <= ox_a;
      oy_b     <= oy_a;
      h1_b     <= $signed(rd[0]);
      if (ox_a <= oy_a) begin
        da_b <= 25'($signed(rd[2])) - 25'($signed(rd[1]));
        db_b <= 25'($signed(rd[1])) - 25'($signed(rd[0]));
        v0_b <= 26'($signed(rd[1])) - 26'($signed(rd[2]))
              + ((ox_a == oy_a) ? 26'($signed(rd[0])) - 26'($signed(rd[3])) : 26'sd0);
        v1_b <= 26'($signed(rd[0])) - 26'($signed(rd[1]))
              + ((ox_a == oy_a) ? 26'($signed(rd[3])) - 26'($signed(rd[2])) : 26'sd0);
        v2_b <= (ox_a == oy_a) ? 10'd512 : 10'd256;
      end else begin
        da_b <= 25'($signed(rd[3])) - 25'($signed(rd[0]));
        db_b <= 25'($signed(rd[2])) - 25'($signed(rd[3]));
        v0_b <= 26'($signed(rd[0])) - 26'($signed(rd[3]));
        v1_b <= 26'($signed(rd[3])) - 26'($signed(rd[2]));
        v2_b <= 10'd256;
      end
    end
  end

  // Stage c: offset products and the common magnitude shift.
  logic [25:0] m0_c, m1_c, m_or;
  logic [3:0]  sh_c;

  always_comb begin
    m0_c = v0_b[25] ? 26'(-v0_b) : 26'(v0_b);
    m1_c = v1_b[25] ? 26'(-v1_b) : 26'(v1_b);
    m_or = m0_c | m1_c | 26'(v2_b);
    sh_c = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if ((m_or >> (14 + k)) != 26'd0) sh_c = 4'(k);
    end
  end

  hhn_pkg::status_t   status_c;
  logic signed [23:0] h1_c;
  logic signed [33:0] pa_c, pb_c;
  logic [2:0][14:0]   mag_c;
  logic [2:0]         neg_c;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      status_c <= status_b;
      h1_c     <= h1_b;
      pa_c     <= da_b * $signed({1'b0, ox_b});
      pb_c     <= db_b * $signed({1'b0, oy_b});
      mag_c[0] <= 15'(m0_c >> sh_c);
      mag_c[1] <= 15'(m1_c >> sh_c);
      mag_c[2] <= 15'(26'(v2_b) >> sh_c);
      neg_c    <= {1'b0, v1_b[25], v0_b[25]};
    end
  end

  // Stage d: rounded, saturated height and the squared magnitudes.
  logic signed [35:0] acc_d;
  logic signed [27:0] hf_d;
  logic signed [23:0] hsat_d;

  always_comb begin
    acc_d = $signed({{4{h1_c[23]}}, h1_c, 8'd0}) + 36'sd128 + 36'(pa_c) + 36'(pb_c);
    hf_d  = acc_d[35:8];
    if (hf_d > 28'sd8388607)       hsat_d = 24'sh7FFFFF;
    else if (hf_d < -28'sd8388608) hsat_d = 24'sh800000;
    else                           hsat_d = hf_d[23:0];
  end

  hhn_pkg::status_t   status_d;
  logic signed [23:0] height_d;
  logic [2:0][14:0]   mag_d;
  logic [2:0]         neg_d;
  logic [29:0]        sqr_d [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      status_d <= status_c;
      height_d <= (status_c == hhn_pkg::ST_DONE) ? hsat_d : 24'sd0;
      mag_d    <= mag_c;
      neg_d    <= neg_c;
      for (int i = 0; i < 3; i++) begin
        sqr_d[i] <= 30'(mag_c[i]) * 30'(mag_c[i]);
      end
    end
  end

  // Stage e: sum of squares.
  hhn_pkg::item_t item_e;
  logic [31:0]    sum_e;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      item_e.status <= status_d;
      item_e.height <= height_d;
      item_e.neg    <= neg_d;
      item_e.mag    <= mag_d;
      sum_e         <= 32'(sqr_d[0]) + 32'(sqr_d[1]) + 32'(sqr_d[2]);
    end
  end

  // Square root of the sum scaled by 2^28, two result bits a stage.
  hhn_pkg::sq_t   sq_st   [hhn_pkg::SQ_STAGES];
  logic [31:0]    sq_x    [hhn_pkg::SQ_STAGES];
  hhn_pkg::item_t sq_item [hhn_pkg::SQ_STAGES];

  for (genvar j = 0; j < hhn_pkg::SQ_STAGES; j++) begin : g_sq
    hhn_pkg::sq_t   cur, mid, nxt;
    logic [31:0]    x_in;
    hhn_pkg::item_t it_in;

    if (j == 0) begin : g_first
      assign cur   = '0;
      assign x_in  = sum_e;
      assign it_in = item_e;
    end else begin : g_next
      assign cur   = sq_st[j-1];
      assign x_in  = sq_x[j-1];
      assign it_in = sq_item[j-1];
    end

    always_comb begin
      mid = hhn_pkg::sqrt_step(cur, x_in[31:30]);
      nxt = hhn_pkg::sqrt_step(mid, x_in[29:28]);
    end

    always_ff @(posedge clk) begin
      if (en[hhn_pkg::ST_SQ0 + j]) begin
        sq_st[j]   <= nxt;
        sq_x[j]    <= {x_in[27:0], 4'd0};
        sq_item[j] <= it_in;
      end
    end
  end

  // Three rounded divisions by the length, two quotient bits a stage.
  hhn_pkg::dv_t   dv_st   [hhn_pkg::DV_STAGES][3];
  logic [15:0]    dv_low  [hhn_pkg::DV_STAGES][3];
  logic [29:0]    dv_len  [hhn_pkg::DV_STAGES];
  hhn_pkg::item_t dv_item [hhn_pkg::DV_STAGES];

  for (genvar j = 0; j < hhn_pkg::DV_STAGES; j++) begin : g_dv
    hhn_pkg::dv_t   cur [3];
    hhn_pkg::dv_t   nxt [3];
    logic [15:0]    low_in [3];
    logic [29:0]    len_in;
    hhn_pkg::item_t it_in;

    if (j == 0) begin : g_first
      logic [43:0] num [3];
      assign len_in = sq_st[hhn_pkg::SQ_STAGES-1].root;
      assign it_in  = sq_item[hhn_pkg::SQ_STAGES-1];
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign num[i]    = {1'b0, it_in.mag[i], 28'd0} + {15'd0, len_in[29:1]};
        assign cur[i]    = '{rem: {2'b00, num[i][43:16]}, quo: 16'd0};
        assign low_in[i] = num[i][15:0];
      end
    end else begin : g_next
      assign len_in = dv_len[j-1];
      assign it_in  = dv_item[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_cp
        assign cur[i]    = dv_st[j-1][i];
        assign low_in[i] = dv_low[j-1][i];
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        nxt[i] = hhn_pkg::div_step(hhn_pkg::div_step(cur[i], low_in[i][15], len_in),
                                   low_in[i][14], len_in);
      end
    end

    always_ff @(posedge clk) begin
      if (en[hhn_pkg::ST_DV0 + j]) begin
        for (int i = 0; i < 3; i++) begin
          dv_st[j][i]  <= nxt[i];
          dv_low[j][i] <= {low_in[i][13:0], 2'b00};
        end
        dv_len[j]  <= len_in;
        dv_item[j] <= it_in;
      end
    end
  end

  // Output register: clamp, sign and zero the normal for non-query words.
  hhn_pkg::item_t it_last;
  logic [15:0]    q_sat [3];
  logic [15:0]    n_out [3];

  assign it_last = dv_item[hhn_pkg::DV_STAGES-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_len[hhn_pkg::DV_STAGES-1] == 30'd0) begin
        q_sat[i] = 16'd0;
      end else if (dv_st[hhn_pkg::DV_STAGES-1][i].quo > hhn_pkg::NORM_ONE) begin
        q_sat[i] = hhn_pkg::NORM_ONE;
      end else begin
        q_sat[i] = dv_st[hhn_pkg::DV_STAGES-1][i].quo;
      end
      if (it_last.status != hhn_pkg::ST_DONE) n_out[i] = 16'd0;
      else if (it_last.neg[i])                n_out[i] = 16'(-q_sat[i]);
      else                                    n_out[i] = q_sat[i];
    end
  end

  logic [1:0]  out_status;
  logic [71:0] out_data;

  always_ff @(posedge clk) begin
    if (en[hhn_pkg::ST_OUT]) begin
      out_status <= it_last.status;
      out_data   <= {n_out[2], n_out[1], n_out[0], it_last.height};
    end
  end

  assign m_axis_tvalid = v[hhn_pkg::ST_OUT];
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = out_data;

  // An empty output register never holds back the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // Flagged and write words carry an all-zero payload.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == hhn_pkg::ST_OOB || m_axis_tuser == hhn_pkg::ST_WRITE)
    |-> m_axis_tdata == 72'd0)
    else $error("non-query word with a non-zero payload");

  // The vertical normal component of a query is never negative.
  a_nz_positive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == hhn_pkg::ST_DONE |-> !m_axis_tdata[71])
    else $error("negative vertical normal component");

  // A word held at the output leaves its stage unchanged into the next cycle.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> v[hhn_pkg::ST_OUT] && $stable(out_data))
    else $error("output word lost while stalled");

endmodule
